// ===== hw/rtl/slci_pkg.sv =====
package slci_pkg;

	// Default width of the blink and pulse down-counters.
	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TICK_W     = 16;
	localparam int RETRY_W    = 8;
	localparam int LEVEL_W    = 8;
	localparam int BRIGHT_W   = 7;
	localparam int BRIGHT_N   = 1 << BRIGHT_W;

	// Beat layouts.
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 32;

	// Reset values of the configuration registers.
	localparam int RST_BRIGHT    = 20;
	localparam int RST_RETRIES   = 5;
	localparam int RST_FAST      = 100;
	localparam int RST_FLASH_ON  = 200;
	localparam int RST_FLASH_OFF = 2800;
	localparam int RST_PULSE     = 150;
	localparam int RST_PIN_HIGH  = 1;

	localparam int FULL_SCALE = 255;
	localparam int PCT_SCALE  = 100;

	typedef enum logic [3:0] {
		OP_TICK     = 4'd0,
		OP_STA      = 4'd1,
		OP_DISC     = 4'd2,
		OP_GOT_IP   = 4'd3,
		OP_AP_START = 4'd4,
		OP_AP_STOP  = 4'd5,
		OP_UI_ON    = 4'd6,
		OP_UI_OFF   = 4'd7,
		OP_JIGGLER  = 4'd8,
		OP_PULSE    = 4'd9
	} opcode_t;

	typedef enum logic [1:0] {
		LINK_DISC       = 2'd0,
		LINK_CONNECTING = 2'd1,
		LINK_CONNECTED  = 2'd2,
		LINK_AP         = 2'd3
	} link_t;

	typedef enum logic [2:0] {
		COL_OFF   = 3'd0,
		COL_RED   = 3'd1,
		COL_GREEN = 3'd2,
		COL_BLUE  = 3'd3,
		COL_WHITE = 3'd4
	} colour_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHT    = 3'd0,
		REG_RETRIES   = 3'd1,
		REG_FAST      = 3'd2,
		REG_FLASH_ON  = 3'd3,
		REG_FLASH_OFF = 3'd4,
		REG_PULSE     = 3'd5,
		REG_PIN_HIGH  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	typedef logic [LEVEL_W-1:0] gamma_lut_t [BRIGHT_N];

	// Squared gamma curve, evaluated at elaboration for every brightness code.
	function automatic gamma_lut_t build_gamma();
		gamma_lut_t t;
		int b;
		int lin;
		for (int i = 0; i < BRIGHT_N; i++) begin
			b = (i > PCT_SCALE) ? PCT_SCALE : i;
			lin = b * FULL_SCALE / PCT_SCALE;
			t[i] = LEVEL_W'(lin * lin / FULL_SCALE);
		end
		return t;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

// ===== hw/rtl/slci_ctrl.sv =====
module slci_ctrl
	import slci_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The result register must be free or draining this cycle.
				if (sts.out_free) begin
					cmd.execute = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_EXEC)
		else $error("capture did not move to execute");
	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> sts.out_free && !s_tready)
		else $error("execute while result register busy");
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> !cmd.execute)
		else $error("two executes for one beat");
`endif

endmodule

// ===== hw/rtl/slci_dp.sv =====
module slci_dp
	import slci_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  ctrl_cmd_t              cmd,
	output dp_sts_t                sts,
	input  logic [S_TDATA_W-1:0]   s_tdata,
	input  logic [S_TUSER_W-1:0]   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata
);

	localparam int WW = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

	typedef struct packed {
		logic                  lit;
		logic                  bcol;
		colour_t               shown;
		logic [TIMER_BITS-1:0] brem;
		logic                  brun;
	} disp_t;

	// Configuration.
	logic [LEVEL_W-1:0]  level_q;
	logic [RETRY_W-1:0]  max_retries_q;
	logic [TICK_W-1:0]   fast_q;
	logic [TICK_W-1:0]   flash_on_q;
	logic [TICK_W-1:0]   flash_off_q;
	logic [TICK_W-1:0]   pulse_q;
	logic                pin_high_q;

	// Indicator state.
	disp_t                 d_q;
	link_t                 link_q;
	logic [RETRY_W-1:0]    retry_q;
	logic                  web_q;
	logic                  jig_q;
	logic [TIMER_BITS-1:0] prem_q;
	logic                  prun_q;
	logic [1:0]            flags_q;

	// Captured input beat.
	logic [S_TUSER_W-1:0]  op_q;
	logic                  jig_in_q;

	// Output register.
	logic                  out_valid_q;
	logic [M_TDATA_W-1:0]  out_data_q;

	disp_t                 d_n;
	link_t                 link_n;
	logic [RETRY_W-1:0]    retry_n;
	logic                  web_n;
	logic                  jig_n;
	logic [TIMER_BITS-1:0] prem_n;
	logic                  prun_n;
	logic [1:0]            flags_n;
	logic                  req_n;
	logic [TIMER_BITS-1:0] ld_fast;
	logic [TIMER_BITS-1:0] ld_on;
	logic [TIMER_BITS-1:0] ld_off;
	logic [TIMER_BITS-1:0] ld_pulse;
	logic [LEVEL_W-1:0]    red_n;
	logic [LEVEL_W-1:0]    green_n;
	logic [LEVEL_W-1:0]    blue_n;
	logic                  pin_n;

	// Zero loads as one; counts beyond the timer width saturate.
	function automatic logic [TIMER_BITS-1:0] tload(input logic [TICK_W-1:0] v);
		logic [WW-1:0] w;
		w = WW'(v);
		if (v == '0) begin
			return TONE;
		end
		if (w > WW'(TMAX)) begin
			return TMAX;
		end
		return TIMER_BITS'(w);
	endfunction

	function automatic disp_t prio(input disp_t di, input logic web, input link_t lk,
			input logic jg, input logic [TIMER_BITS-1:0] lf,
			input logic [TIMER_BITS-1:0] loff);
		disp_t r;
		r      = di;
		r.brun = 1'b0;
		r.brem = '0;
		if (web) begin
			r.shown = COL_BLUE;
			r.lit   = 1'b1;
		end else begin
			r.lit   = 1'b0;
			r.shown = COL_OFF;
			if (lk != LINK_CONNECTED) begin
				r.bcol = 1'b0;
				r.brem = lf;
				r.brun = 1'b1;
			end else if (jg) begin
				r.bcol = 1'b1;
				r.brem = loff;
				r.brun = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic disp_t blink_exp(input disp_t di, input logic web, input link_t lk,
			input logic jg, input logic [TIMER_BITS-1:0] lf,
			input logic [TIMER_BITS-1:0] lon, input logic [TIMER_BITS-1:0] loff);
		disp_t r;
		r = di;
		if (web) begin
			r.shown = COL_BLUE;
			r.lit   = 1'b1;
		end else begin
			r.lit = !r.lit;
			if (r.lit) begin
				r.shown = r.bcol ? COL_GREEN : COL_RED;
			end else begin
				r.shown = COL_OFF;
			end
			if (jg && lk == LINK_CONNECTED) begin
				r.brem = r.lit ? lon : loff;
				r.brun = 1'b1;
			end else if (lk != LINK_CONNECTED) begin
				r.brem = lf;
				r.brun = 1'b1;
			end
		end
		return r;
	endfunction

	assign ld_fast  = tload(fast_q);
	assign ld_on    = tload(flash_on_q);
	assign ld_off   = tload(flash_off_q);
	assign ld_pulse = tload(pulse_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= GAMMA_LUT[RST_BRIGHT];
			max_retries_q <= RETRY_W'(RST_RETRIES);
			fast_q        <= TICK_W'(RST_FAST);
			flash_on_q    <= TICK_W'(RST_FLASH_ON);
			flash_off_q   <= TICK_W'(RST_FLASH_OFF);
			pulse_q       <= TICK_W'(RST_PULSE);
			pin_high_q    <= 1'(RST_PIN_HIGH);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BRIGHT:    level_q       <= GAMMA_LUT[cfg_data[BRIGHT_W-1:0]];
				REG_RETRIES:   max_retries_q <= cfg_data[RETRY_W-1:0];
				REG_FAST:      fast_q        <= cfg_data[TICK_W-1:0];
				REG_FLASH_ON:  flash_on_q    <= cfg_data[TICK_W-1:0];
				REG_FLASH_OFF: flash_off_q   <= cfg_data[TICK_W-1:0];
				REG_PULSE:     pulse_q       <= cfg_data[TICK_W-1:0];
				REG_PIN_HIGH:  pin_high_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= s_tuser;
			jig_in_q <= s_tdata[0];
		end
	end

	always_comb begin
		d_n     = d_q;
		link_n  = link_q;
		retry_n = retry_q;
		web_n   = web_q;
		jig_n   = jig_q;
		prem_n  = prem_q;
		prun_n  = prun_q;
		flags_n = flags_q;
		req_n   = 1'b0;
		case (opcode_t'(op_q))
			OP_TICK: begin
				// Blink timer first, then the pulse timer.
				if (d_n.brun) begin
					d_n.brem = d_n.brem - TONE;
					if (d_n.brem == '0) begin
						d_n.brun = 1'b0;
						d_n = blink_exp(d_n, web_n, link_n, jig_n, ld_fast, ld_on, ld_off);
					end
				end
				if (prun_n) begin
					prem_n = prem_n - TONE;
					if (prem_n == '0) begin
						prun_n = 1'b0;
						d_n = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
					end
				end
			end
			OP_STA: begin
				req_n  = 1'b1;
				link_n = LINK_CONNECTING;
				d_n    = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
			end
			OP_DISC: begin
				if (retry_q < max_retries_q) begin
					req_n   = 1'b1;
					retry_n = retry_q + RETRY_W'(1);
				end else begin
					flags_n[1] = 1'b1;
					link_n     = LINK_DISC;
					d_n        = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
				end
			end
			OP_GOT_IP: begin
				retry_n    = '0;
				flags_n[0] = 1'b1;
				link_n     = LINK_CONNECTED;
				d_n        = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
			end
			OP_AP_START: begin
				link_n = LINK_AP;
				d_n    = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
			end
			OP_AP_STOP: begin
				link_n = LINK_DISC;
				d_n    = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
			end
			OP_UI_ON: begin
				web_n     = 1'b1;
				d_n.brun  = 1'b0;
				d_n.brem  = '0;
				prun_n    = 1'b0;
				prem_n    = '0;
				d_n.shown = COL_BLUE;
				d_n.lit   = 1'b1;
			end
			OP_UI_OFF: begin
				web_n = 1'b0;
				d_n   = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
			end
			OP_JIGGLER: begin
				jig_n = jig_in_q;
				d_n   = prio(d_n, web_n, link_n, jig_n, ld_fast, ld_off);
			end
			OP_PULSE: begin
				if (!web_q) begin
					d_n.brun  = 1'b0;
					d_n.brem  = '0;
					d_n.shown = COL_WHITE;
					d_n.lit   = 1'b1;
					prem_n    = ld_pulse;
					prun_n    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		red_n   = (d_n.shown == COL_RED || d_n.shown == COL_WHITE) ? level_q : '0;
		green_n = (d_n.shown == COL_GREEN || d_n.shown == COL_WHITE) ? level_q : '0;
		blue_n  = (d_n.shown == COL_BLUE || d_n.shown == COL_WHITE) ? level_q : '0;
		pin_n   = ((red_n | green_n | blue_n) != '0) == pin_high_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= '{lit: 1'b0, bcol: 1'b0, shown: COL_OFF, brem: '0, brun: 1'b0};
			link_q  <= LINK_DISC;
			retry_q <= '0;
			web_q   <= 1'b0;
			jig_q   <= 1'b0;
			prem_q  <= '0;
			prun_q  <= 1'b0;
			flags_q <= '0;
		end else if (cmd.execute) begin
			d_q     <= d_n;
			link_q  <= link_n;
			retry_q <= retry_n;
			web_q   <= web_n;
			jig_q   <= jig_n;
			prem_q  <= prem_n;
			prun_q  <= prun_n;
			flags_q <= flags_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			out_data_q <= {2'b00, flags_n[1], flags_n[0], req_n, link_n, pin_n,
				blue_n, green_n, red_n};
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

`ifndef SYNTH
	a_blink_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		d_q.brun |-> d_q.brem != '0)
		else $error("blink timer running at zero");
	a_pulse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		prun_q |-> prem_q != '0)
		else $error("pulse timer running at zero");
	a_ui_blue: assert property (@(posedge clk) disable iff (!arst_n)
		web_q |-> d_q.shown == COL_BLUE && !d_q.brun && !prun_q)
		else $error("web UI active without solid blue");
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q)
		else $error("result dropped while stalled");
`endif

endmodule

// ===== hw/rtl/status_led_connection_indicator_top.sv =====
// Channel      Handshake               Payload
// s_ (input)   s_tvalid / s_tready     s_tuser: opcode; s_tdata: jiggler_on
// m_ (result)  m_tvalid / m_tready     m_tdata: levels, pin, link state, request, flags
// cfg (write)  cfg_valid / cfg_ready   cfg_index: register; cfg_data: value
//
// Each input beat is captured in the idle state and then, in the execute state,
// updates the link and display state and loads the result register. A new beat is
// taken while the previous result still waits downstream; the update stalls
// only while the result register is full and not being drained.
// Reset is asynchronous and active low and restores configuration, link and
// display state and the result valid flag; configuration writes are always accepted.
module status_led_connection_indicator_top
	import slci_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input events and ticks.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // [0] jiggler_on, [7:1] zero
	input  logic [S_TUSER_W-1:0]  s_tuser,  // [3:0] opcode
	// Results, one beat per input beat.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata   // [7:0] red_level, [15:8] green_level,
	                                        // [23:16] blue_level, [24] pin_level,
	                                        // [26:25] link_state, [27] connect_request,
	                                        // [28] connected_flag, [29] failed_flag,
	                                        // [31:30] zero
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// The register file never back-pressures.
	assign cfg_ready = 1'b1;

	// The controller sequences capture and update of each beat.
	slci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds configuration, link and display state, and the
	// result register. The brightness level comes from a gamma table when
	// the brightness register is written.
	slci_dp #(
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
